// ===== design/ekagm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekagm_pkg
// Shared types and constants of the elliptic integral agm block.
// ----------------------------------------------------------------------------
package ekagm_pkg;

	localparam int IN_W    = 33;
	localparam int IN_FRAC = 32;
	localparam int WF      = 40;
	localparam int AW      = WF + 1;
	localparam int PW      = 2 * AW;
	localparam int KW      = 36;
	localparam int ITW     = 10;
	localparam int TOLW    = 16;
	localparam int NUMW    = 73;
	localparam int CHUNK   = 11;
	localparam int MGW     = 4 * CHUNK;

	localparam logic [NUMW-1:0] PI_NUM = {64'hC90FDAA22168C234, 9'd0};
	localparam logic [KW-1:0]   K_MASK = {KW{1'b1}};

	localparam logic [0:0] REG_TOL   = 1'b0;
	localparam logic [0:0] REG_LIMIT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_INIT_SQ,
		ST_CHECK,
		ST_MUL,
		ST_SQ,
		ST_DIV,
		ST_FINISH
	} ekagm_state_t;

	typedef struct packed {
		logic load;
		logic sqrt_init;
		logic init_done;
		logic mul_start;
		logic sqrt_iter;
		logic update;
		logic div_start;
		logic emit;
	} ekagm_cmd_t;

	typedef struct packed {
		logic is_inf;
		logic is_zero;
		logic busy;
		logic stop;
	} ekagm_stat_t;

endpackage

// ===== design/elliptic_k_agm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptic_k_agm
// Complete elliptic integral of the first kind by the arithmetic-geometric mean.
// ----------------------------------------------------------------------------
// One item at a time. An item with 0 < k2 < 1 runs a 41-step bit-serial
// square root to start the loop; each agm iteration then runs a chunked
// multiply and a 41-step square root, and a 73-step restoring division
// forms pi/(2a). k2 = 0 skips the loop; k2 >= 1 skips the loop and the
// division. The finished result sits in an output register, so the next
// item is taken while it waits.
module elliptic_k_agm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // k2_fraction[32:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // k_value[35:0], iterations[45:36], zero pad
	output logic        m_tuser    // is_infinite
);
	import ekagm_pkg::*;

	logic [TOLW-1:0] tol_q;
	logic [ITW-1:0]  limit_q;
	ekagm_cmd_t      cmd;
	ekagm_stat_t     stat;
	logic [KW-1:0]   k_val;
	logic            inf_val;
	logic [ITW-1:0]  it_val;
	logic            out_free;
	logic [KW-1:0]   k_q;
	logic [ITW-1:0]  it_q;
	logic            inf_q;
	logic            mvalid_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOLW'(1);
			limit_q <= ITW'(1000);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TOL:   tol_q   <= pwdata[TOLW-1:0];
				REG_LIMIT: limit_q <= pwdata[ITW-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TOL:   prdata = 32'(tol_q);
			REG_LIMIT: prdata = 32'(limit_q);
			default:   prdata = '0;
		endcase
	end

	assign out_free = !mvalid_q || m_tready;

	ekagm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	ekagm_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.k2_in   (s_tdata[IN_W-1:0]),
		.tol     (tol_q),
		.limit   (limit_q),
		.stat    (stat),
		.k_out   (k_val),
		.inf_out (inf_val),
		.it_out  (it_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			k_q   <= k_val;
			it_q  <= it_val;
			inf_q <= inf_val;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {2'b00, it_q, k_q};
	assign m_tuser  = inf_q;

endmodule

// ===== design/ekagm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekagm_ctrl
// Sequencer for classification, agm iterations and the final division.
// ----------------------------------------------------------------------------
module ekagm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	input  ekagm_pkg::ekagm_stat_t stat,
	output logic               in_ready,
	output ekagm_pkg::ekagm_cmd_t  cmd
);
	import ekagm_pkg::*;

	ekagm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CLASSIFY;
			ST_CLASSIFY: begin
				if (stat.is_inf) state_d = ST_FINISH;
				else if (stat.is_zero) state_d = ST_DIV;
				else state_d = ST_INIT_SQ;
			end
			ST_INIT_SQ:  if (!stat.busy) state_d = ST_CHECK;
			ST_CHECK:    state_d = stat.stop ? ST_DIV : ST_MUL;
			ST_MUL:      if (!stat.busy) state_d = ST_SQ;
			ST_SQ:       if (!stat.busy) state_d = ST_CHECK;
			ST_DIV:      if (!stat.busy) state_d = ST_FINISH;
			ST_FINISH:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CLASSIFY: begin
				cmd.sqrt_init = !stat.is_inf && !stat.is_zero;
				cmd.div_start = !stat.is_inf && stat.is_zero;
			end
			ST_INIT_SQ: cmd.init_done = !stat.busy;
			ST_CHECK: begin
				cmd.div_start = stat.stop;
				cmd.mul_start = !stat.stop;
			end
			ST_MUL:    cmd.sqrt_iter = !stat.busy;
			ST_SQ:     cmd.update = !stat.busy;
			ST_DIV:    ;
			ST_FINISH: cmd.emit = out_free;
			default:   ;
		endcase
	end

endmodule

// ===== design/ekagm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekagm_dp
// Agm datapath: chunked multiplier, bit-serial square root and divider.
// ----------------------------------------------------------------------------
module ekagm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ekagm_pkg::ekagm_cmd_t         cmd,
	input  logic [ekagm_pkg::IN_W-1:0]    k2_in,
	input  logic [ekagm_pkg::TOLW-1:0]    tol,
	input  logic [ekagm_pkg::ITW-1:0]     limit,
	output ekagm_pkg::ekagm_stat_t        stat,
	output logic [ekagm_pkg::KW-1:0]      k_out,
	output logic                          inf_out,
	output logic [ekagm_pkg::ITW-1:0]     it_out
);
	import ekagm_pkg::*;

	logic [IN_FRAC-1:0] k2_q;
	logic               inf_q, zero_q;
	logic [AW-1:0]      a_q, g_q, na_q, diff;
	logic [ITW-1:0]     it_q;

	// multiplier
	logic               mul_busy_q;
	logic [1:0]         mul_cnt_q;
	logic [MGW-1:0]     mg_q;
	logic [PW-1:0]      prod_q;
	logic [AW+CHUNK-1:0] pp;

	// square root
	logic               sq_busy_q;
	logic [5:0]         sq_cnt_q;
	logic [PW-1:0]      rad_q;
	logic [AW-1:0]      root_q;
	logic [AW+2:0]      srem_q, srem_sh, trial;

	// divider
	logic               dv_busy_q;
	logic [6:0]         dv_cnt_q;
	logic [NUMW-1:0]    num_q, quo_q;
	logic [AW-1:0]      drem_q;
	logic [AW:0]        drem_sh;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k2_q   <= k2_in[IN_FRAC-1:0];
			inf_q  <= k2_in[IN_W-1];
			zero_q <= (k2_in == '0);
			a_q    <= AW'(1) << WF;
			it_q   <= '0;
		end
		if (cmd.init_done) begin
			g_q  <= root_q;
			it_q <= ITW'(1);
		end
		if (cmd.mul_start) begin
			na_q <= AW'(({1'b0, a_q} + {1'b0, g_q}) >> 1);
		end
		if (cmd.update) begin
			a_q  <= na_q;
			g_q  <= root_q;
			it_q <= it_q + ITW'(1);
		end
	end

	assign diff = (a_q > g_q) ? a_q - g_q : g_q - a_q;

	// chunked multiply, top chunk of g first
	assign pp = AW'(a_q) * mg_q[MGW-1 -: CHUNK];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q  <= '0;
		end else if (mul_busy_q) begin
			mul_cnt_q <= mul_cnt_q + 2'd1;
			if (mul_cnt_q == 2'd3) mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mg_q   <= MGW'(g_q);
			prod_q <= '0;
		end else if (mul_busy_q) begin
			mg_q   <= mg_q << CHUNK;
			prod_q <= (prod_q << CHUNK) + PW'(pp);
		end
	end

	// square root, two radicand bits per step
	assign srem_sh = {srem_q[AW:0], rad_q[PW-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (cmd.sqrt_init || cmd.sqrt_iter) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= '0;
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q + 6'd1;
			if (sq_cnt_q == 6'(AW - 1)) sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init || cmd.sqrt_iter) begin
			rad_q  <= cmd.sqrt_init
				? PW'({(IN_W)'(1) << IN_FRAC} - {1'b0, k2_q}) << (2 * WF - IN_FRAC)
				: prod_q;
			root_q <= '0;
			srem_q <= '0;
		end else if (sq_busy_q) begin
			rad_q <= rad_q << 2;
			if (srem_sh >= trial) begin
				srem_q <= srem_sh - trial;
				root_q <= {root_q[AW-2:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[AW-2:0], 1'b0};
			end
		end
	end

	// restoring division of the pi constant by a
	assign drem_sh = {drem_q, num_q[NUMW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= '0;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q + 7'd1;
			if (dv_cnt_q == 7'(NUMW - 1)) dv_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q  <= PI_NUM;
			quo_q  <= '0;
			drem_q <= '0;
		end else if (dv_busy_q) begin
			num_q <= num_q << 1;
			if (drem_sh >= {1'b0, a_q}) begin
				drem_q <= AW'(drem_sh - {1'b0, a_q});
				quo_q  <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				drem_q <= AW'(drem_sh);
				quo_q  <= {quo_q[NUMW-2:0], 1'b0};
			end
		end
	end

	assign stat.is_inf  = inf_q;
	assign stat.is_zero = zero_q;
	assign stat.busy    = mul_busy_q || sq_busy_q || dv_busy_q;
	assign stat.stop    = (it_q >= limit)
		|| ((it_q != ITW'(1)) && (diff <= AW'(tol)));

	assign inf_out = inf_q;
	assign it_out  = it_q;
	assign k_out   = (inf_q || (quo_q[NUMW-1:KW] != '0)) ? K_MASK : quo_q[KW-1:0];

endmodule
